FILE: sv/pressure_sensor_compensation_macros.svh
// assertion helpers used by the checker module
`ifndef PRESSURE_SENSOR_COMPENSATION_MACROS_SVH
`define PRESSURE_SENSOR_COMPENSATION_MACROS_SVH

// same-cycle implication
`define PSC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("psc check failed");

// next-cycle implication
`define PSC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("psc check failed");

`endif

FILE: sv/psc_pkg.sv
package psc_pkg;

  localparam int unsigned NumRegs = 7;
  localparam int unsigned AddrW   = 5;
  localparam int unsigned IdxW    = 3;

  // divider widths
  localparam int unsigned DmW = 51;
  localparam int unsigned RW  = 52;
  localparam int unsigned QW  = 31;
  localparam int unsigned NlW = 11;

  localparam logic [1:0] StatusOk    = 2'd0;
  localparam logic [1:0] StatusRange = 2'd1;
  localparam logic [1:0] StatusZero  = 2'd2;

  localparam logic signed [15:0] TempLo  = 16'sd0;
  localparam logic signed [15:0] TempHi  = 16'sd12800;
  localparam logic signed [23:0] PressLo = 24'sd45876;
  localparam logic signed [23:0] PressHi = 24'sd393216;

  // divide by three: offset keeps the operand positive, then reciprocal multiply
  localparam int unsigned TBias  = 2097152;
  localparam int unsigned TOff   = 3 * TBias;
  localparam int unsigned TRecip = 22369622;
  localparam int unsigned TShift = 26;

  typedef struct packed {
    logic signed [13:0] c0;
    logic signed [13:0] c1;
    logic signed [9:0]  c2;
    logic signed [9:0]  c3;
    logic signed [9:0]  c4;
    logic signed [9:0]  c5;
    logic signed [9:0]  c6;
    logic signed [9:0]  a0;
    logic signed [9:0]  a1;
    logic signed [9:0]  a2;
  } psc_coef_t;

  typedef struct packed {
    logic [RW-1:0]      r;
    logic [DmW-1:0]     dm;
    logic [NlW-1:0]     nlow;
    logic [QW-1:0]      q;
    logic               neg;
    logic               ovf;
    logic               zero;
    logic signed [15:0] t;
  } psc_div_t;

endpackage

FILE: sv/psc_in_if.sv
interface psc_in_if;
  logic        valid;
  logic        ready;
  logic [23:0] pressure_count;
  logic [23:0] temperature_count;

  modport source(output valid, pressure_count, temperature_count, input ready);
  modport sink(input valid, pressure_count, temperature_count, output ready);
endinterface

FILE: sv/psc_out_if.sv
interface psc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] temperature_out;
  logic signed [23:0] pressure_out;
  logic [1:0]         status;

  modport source(output valid, temperature_out, pressure_out, status, input ready);
  modport sink(input valid, temperature_out, pressure_out, status, output ready);
endinterface

FILE: sv/psc_cfg.sv
module psc_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [psc_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output psc_pkg::psc_coef_t         coef_o
);

  logic [15:0] word_q [psc_pkg::NumRegs];
  logic [psc_pkg::IdxW-1:0] idx;
  logic wr;

  assign idx    = paddr[psc_pkg::AddrW-1:2];
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < psc_pkg::NumRegs; i++) word_q[i] <= '0;
    end else if (wr && (idx < psc_pkg::IdxW'(psc_pkg::NumRegs))) begin
      word_q[idx] <= pwdata[15:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (idx < psc_pkg::IdxW'(psc_pkg::NumRegs)) prdata = {16'b0, word_q[idx]};
  end

  // coefficient fields straddle word boundaries
  always_comb begin
    coef_o.c0 = word_q[0][15:2];
    coef_o.c1 = {word_q[0][1:0], word_q[1][15:4]};
    coef_o.c2 = {word_q[1][3:0], word_q[2][15:10]};
    coef_o.c3 = word_q[2][9:0];
    coef_o.c4 = word_q[3][15:6];
    coef_o.c5 = {word_q[3][5:0], word_q[4][15:12]};
    coef_o.c6 = word_q[4][11:2];
    coef_o.a0 = {word_q[4][1:0], word_q[5][15:8]};
    coef_o.a1 = {word_q[5][7:0], word_q[6][15:14]};
    coef_o.a2 = word_q[6][13:4];
  end

endmodule

FILE: sv/psc_front.sv
module psc_front #(
  parameter int unsigned ADC_BITS = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [23:0]        pcount_i,
  input  logic [23:0]        tcount_i,
  input  psc_pkg::psc_coef_t coef_i,
  output logic               valid_o,
  output psc_pkg::psc_div_t  div_o
);

  localparam logic [23:0] CntMask = 24'((33'd1 << ADC_BITS) - 33'd1);

  logic [5:0] v_q;

  logic [23:0] x1_q, d1_q;
  logic [23:0] x2_q, sq_q, d2_q;
  logic [47:0] sqfull;
  logic signed [24:0] xs, x2s;
  logic signed [34:0] a1x_d, a2x_d, c3x_d, c4x_d, c5x_d, c6x_d;
  logic signed [34:0] a1x_q, a2x_q, c3x_q, c4x_q, c5x_q, c6x_q;
  logic [23:0] d3_q;
  logic signed [47:0] tsum, vv;
  logic signed [51:0] tops_d, bots_d, tops_q, bots_q;
  logic [23:0] u_d, u_q;
  logic [psc_pkg::DmW-1:0] nm_d, dm_d, nm_q, dm_q;
  logic neg_q, zero_q;
  logic [48:0] tprod_d, tprod_q;
  logic signed [23:0] tfull;
  psc_pkg::psc_div_t div_d, div_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else if (en_i) v_q <= {v_q[4:0], valid_i};
  end

  always_comb begin
    sqfull = x1_q * x1_q;
    xs  = $signed({1'b0, x2_q});
    x2s = $signed({1'b0, sq_q});
    a1x_d = coef_i.a1 * xs;
    a2x_d = coef_i.a2 * x2s;
    c3x_d = coef_i.c3 * xs;
    c4x_d = coef_i.c4 * x2s;
    c5x_d = coef_i.c5 * xs;
    c6x_d = coef_i.c6 * x2s;

    // rounded temperature numerator, divided by the sensor scale
    tsum = (48'(coef_i.a0) <<< (8 + ADC_BITS))
         + 48'sd1536 * (48'(a1x_q) + 48'(a2x_q))
         + (48'sd3 <<< (ADC_BITS - 1));
    vv   = tsum >>> ADC_BITS;
    u_d  = 24'(vv + 48'(psc_pkg::TOff));

    tops_d = $signed(52'(d3_q) << ADC_BITS)
           + (52'(coef_i.c0) <<< (9 + ADC_BITS))
           + ((52'(c3x_q) + 52'(c4x_q)) <<< 15);
    bots_d = (52'(coef_i.c1) <<< (11 + ADC_BITS))
           + ((52'(c5x_q) + 52'(c6x_q)) <<< 16);

    nm_d = tops_q[51] ? psc_pkg::DmW'(-tops_q) : tops_q[psc_pkg::DmW-1:0];
    dm_d = bots_q[51] ? psc_pkg::DmW'(-bots_q) : bots_q[psc_pkg::DmW-1:0];
    tprod_d = 49'(u_q) * 49'(psc_pkg::TRecip);

    tfull = $signed({1'b0, tprod_q[48:psc_pkg::TShift]}) - 24'(psc_pkg::TBias);
    div_d.r    = psc_pkg::RW'(nm_q >> psc_pkg::NlW);
    div_d.dm   = dm_q;
    div_d.nlow = nm_q[psc_pkg::NlW-1:0];
    div_d.q    = '0;
    div_d.neg  = neg_q;
    div_d.zero = zero_q;
    // quotient would reach the integer cap
    div_d.ovf  = {11'b0, nm_q} >= {dm_q, 11'b0};
    if (tfull > 24'sd32767)       div_d.t = 16'sh7fff;
    else if (tfull < -24'sd32768) div_d.t = 16'sh8000;
    else                          div_d.t = tfull[15:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_q  <= tcount_i & CntMask;
      d1_q  <= pcount_i & CntMask;
      x2_q  <= x1_q;
      sq_q  <= sqfull[ADC_BITS +: 24];
      d2_q  <= d1_q;
      a1x_q <= a1x_d;
      a2x_q <= a2x_d;
      c3x_q <= c3x_d;
      c4x_q <= c4x_d;
      c5x_q <= c5x_d;
      c6x_q <= c6x_d;
      d3_q  <= d2_q;
      tops_q <= tops_d;
      bots_q <= bots_d;
      u_q    <= u_d;
      nm_q   <= nm_d;
      dm_q   <= dm_d;
      neg_q  <= tops_q[51] ^ bots_q[51];
      zero_q <= (bots_q == '0);
      tprod_q <= tprod_d;
      div_q  <= div_d;
    end
  end

  assign valid_o = v_q[5];
  assign div_o   = div_q;

endmodule

FILE: sv/psc_div.sv
module psc_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  psc_pkg::psc_div_t div_i,
  output logic              valid_o,
  output psc_pkg::psc_div_t div_o
);

  localparam int unsigned Steps = psc_pkg::QW;

  logic [Steps-1:0]  v_q;
  psc_pkg::psc_div_t stage_q [Steps];

  // one restoring step: bring in the next numerator bit, subtract when it fits
  function automatic psc_pkg::psc_div_t div_step(input psc_pkg::psc_div_t cur);
    psc_pkg::psc_div_t nxt;
    logic [psc_pkg::RW-1:0] rs;
    logic [psc_pkg::RW-1:0] dx;
    nxt      = cur;
    rs       = {cur.r[psc_pkg::RW-2:0], cur.nlow[psc_pkg::NlW-1]};
    dx       = {1'b0, cur.dm};
    nxt.nlow = {cur.nlow[psc_pkg::NlW-2:0], 1'b0};
    if (rs >= dx) begin
      nxt.r = rs - dx;
      nxt.q = {cur.q[psc_pkg::QW-2:0], 1'b1};
    end else begin
      nxt.r = rs;
      nxt.q = {cur.q[psc_pkg::QW-2:0], 1'b0};
    end
    return nxt;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else if (en_i) v_q <= {v_q[Steps-2:0], valid_i};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q[0] <= div_step(div_i);
      for (int k = 1; k < Steps; k++) stage_q[k] <= div_step(stage_q[k-1]);
    end
  end

  assign valid_o = v_q[Steps-1];
  assign div_o   = stage_q[Steps-1];

endmodule

FILE: sv/psc_back.sv
module psc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  psc_pkg::psc_div_t  div_i,
  input  psc_pkg::psc_coef_t coef_i,
  output logic               valid_o,
  output logic signed [15:0] temp_o,
  output logic signed [23:0] press_o,
  output logic [1:0]         status_o
);

  logic [4:0] v_q;
  logic       vout_q;

  logic [31:0] qm_d, qm_q;
  logic signed [32:0] y_d, y1_q, y2_q, y3_q, y4_q;
  logic [1:0] zero_q;
  logic [1:0] zpipe_q;
  logic signed [15:0] t1_q, t2_q, t3_q, t4_q, t5_q;
  logic [63:0] qsq_q;
  logic signed [44:0] diff_d, diff_q;
  logic signed [54:0] cp_d, cp_q;
  logic signed [40:0] pq_d, pq_q;
  logic z1_q, z5_q;
  logic signed [45:0] pm, ps, pr;
  logic signed [23:0] psat;
  logic signed [15:0] temp_q;
  logic signed [23:0] press_q;
  logic [1:0] status_q, status_d;

  always_comb begin
    qm_d = div_i.ovf ? 32'h8000_0000 : {1'b0, div_i.q};
    y_d  = div_i.neg ? -$signed({1'b0, qm_d}) : $signed({1'b0, qm_d});
    diff_d = $signed({1'b0, qsq_q[63:20]}) - 45'(y2_q);
    cp_d   = coef_i.c2 * diff_q;
    pq_d   = 41'(y4_q) + 41'(cp_q >>> 15);

    // scale to 1/65536 bar: 15/32 of pq, offset by 0.1 full scale
    pm = (46'(pq_q) <<< 4) - 46'(pq_q) + 46'sd16;
    ps = pm >>> 5;
    pr = ps - 46'sd49152;
    if (pr > 46'sd8388607)       psat = 24'sh7fffff;
    else if (pr < -46'sd8388608) psat = 24'sh800000;
    else                         psat = pr[23:0];

    if (z5_q) begin
      status_d = psc_pkg::StatusZero;
    end else if (t5_q < psc_pkg::TempLo || t5_q > psc_pkg::TempHi ||
                 psat < psc_pkg::PressLo || psat > psc_pkg::PressHi) begin
      status_d = psc_pkg::StatusRange;
    end else begin
      status_d = psc_pkg::StatusOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q    <= '0;
      vout_q <= 1'b0;
    end else if (en_i) begin
      v_q    <= {v_q[3:0], valid_i};
      vout_q <= v_q[4];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      qm_q  <= qm_d;
      y1_q  <= y_d;
      z1_q  <= div_i.zero;
      t1_q  <= div_i.t;
      qsq_q <= qm_q * qm_q;
      y2_q  <= y1_q;
      t2_q  <= t1_q;
      diff_q <= diff_d;
      y3_q  <= y2_q;
      t3_q  <= t2_q;
      cp_q  <= cp_d;
      y4_q  <= y3_q;
      t4_q  <= t3_q;
      pq_q  <= pq_d;
      t5_q  <= t4_q;
      zero_q  <= {zero_q[0], z1_q};
      zpipe_q <= {zpipe_q[0], zero_q[1]};
      temp_q   <= t5_q;
      press_q  <= z5_q ? 24'sd0 : psat;
      status_q <= status_d;
    end
  end

  // zero flag rides alongside the product stages
  assign z5_q = zpipe_q[1];

  assign valid_o  = vout_q;
  assign temp_o   = temp_q;
  assign press_o  = press_q;
  assign status_o = status_q;

endmodule

FILE: sv/pressure_sensor_compensation.sv
// channel   dir  fields                                   handshake
// in_ch     in   pressure_count, temperature_count        valid/ready
// out_ch    out  temperature_out, pressure_out, status    valid/ready
// apb       in   cal_word_0..6 at byte address 4*i        pready tied high
//
// one item per cycle while the output is not stalled; 6 polynomial stages, 31 divider
// stages (one quotient bit each), 5 correction stages and the output register
// all stages advance together; a stalled output holds the whole pipe
// reset clears the valid bits and the calibration words
module pressure_sensor_compensation #(
  parameter int unsigned ADC_BITS = 24
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  psc_in_if.sink                    in_ch,
  psc_out_if.source                 out_ch,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [psc_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  psc_pkg::psc_coef_t coef;
  psc_pkg::psc_div_t  front_div, div_res;
  logic front_v, div_v, out_v, en;

  assign en          = !out_v || out_ch.ready;
  assign in_ch.ready = en;

  psc_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .coef_o(coef)
  );

  psc_front #(.ADC_BITS(ADC_BITS)) u_front (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_ch.valid),
    .pcount_i(in_ch.pressure_count), .tcount_i(in_ch.temperature_count),
    .coef_i(coef), .valid_o(front_v), .div_o(front_div)
  );

  psc_div u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(front_v), .div_i(front_div),
    .valid_o(div_v), .div_o(div_res)
  );

  psc_back u_back (
    .clk_i, .rst_ni, .en_i(en), .valid_i(div_v), .div_i(div_res), .coef_i(coef),
    .valid_o(out_v), .temp_o(out_ch.temperature_out),
    .press_o(out_ch.pressure_out), .status_o(out_ch.status)
  );

  assign out_ch.valid = out_v;

endmodule

FILE: sv/psc_checker.sv
`include "pressure_sensor_compensation_macros.svh"

module psc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic signed [15:0] temp_i,
  input logic signed [23:0] press_i,
  input logic [1:0]         status_i
);

  logic is_zero, is_ok, in_range;

  assign is_zero  = out_valid_i && status_i == psc_pkg::StatusZero;
  assign is_ok    = out_valid_i && status_i == psc_pkg::StatusOk;
  assign in_range = temp_i >= psc_pkg::TempLo && temp_i <= psc_pkg::TempHi &&
                    press_i >= psc_pkg::PressLo && press_i <= psc_pkg::PressHi;

  `PSC_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `PSC_ASSERT_NOW(a_zero, clk_i, rst_ni, is_zero, press_i == 24'sd0)
  `PSC_ASSERT_NOW(a_range, clk_i, rst_ni, is_ok, in_range)

endmodule

bind pressure_sensor_compensation psc_checker u_psc_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .out_valid_i(out_ch.valid),
  .out_ready_i(out_ch.ready),
  .temp_i(out_ch.temperature_out),
  .press_i(out_ch.pressure_out),
  .status_i(out_ch.status)
);
